// ===== hw/rtl/card_id_whitelist_table_defines.svh =====
// Assertion macros shared by the card whitelist RTL.
`ifndef CARD_ID_WHITELIST_TABLE_DEFINES_SVH
`define CARD_ID_WHITELIST_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CIDW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CIDW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cidw_pkg.sv =====
// Widths, operation codes and status codes of the card whitelist table.
package cidw_pkg;

	localparam int FUNC_W     = 2;
	localparam int UPPER_W    = 32;
	localparam int LOWER_W    = 64;
	localparam int ID_W       = UPPER_W + LOWER_W;
	localparam int STATUS_W   = 3;
	localparam int SLOT_IDX_W = 4;

	typedef logic [FUNC_W-1:0]     func_t;
	typedef logic [STATUS_W-1:0]   status_t;
	typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
	typedef logic [ID_W-1:0]       card_id_t;

	// Operations
	localparam func_t FUNC_CHECK  = 2'd0;
	localparam func_t FUNC_ADD    = 2'd1;
	localparam func_t FUNC_REMOVE = 2'd2;

	// Result status codes
	localparam status_t STAT_GRANTED  = 3'd0;
	localparam status_t STAT_DENIED   = 3'd1;
	localparam status_t STAT_ADDED    = 3'd2;
	localparam status_t STAT_PRESENT  = 3'd3;
	localparam status_t STAT_FULL     = 3'd4;
	localparam status_t STAT_REMOVED  = 3'd5;
	localparam status_t STAT_NOTFOUND = 3'd6;

endpackage

// ===== hw/rtl/card_id_whitelist_table.sv =====
// Card whitelist table: slot memory, scan sequencer and result register.
// Each request carries an operation (check, add, remove) and a 96-bit card
// identifier, and yields one result (status, slot_index). Identifiers live in
// a synchronous memory of SLOT_COUNT words with one write port and one read
// port; used marks are flops cleared by reset, so the table is empty right
// after reset with no clearing pass. One request is handled at a time: the
// sequencer reads every slot in turn, one address per cycle, comparing each
// word in the cycle after its read, and finds the lowest matching used slot
// and the lowest free slot in the same pass. A check, add or remove goes
// through the scan, wait and finish states before the next acceptance; the
// unused operation code goes straight to the finish state. A finished
// result sits in an output register, so the next request is taken while the
// result waits for the consumer. slot_index carries the low four bits of the
// slot number and is zero when no slot is involved.
`include "card_id_whitelist_table_defines.svh"

module card_id_whitelist_table #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cidw_pkg::FUNC_W-1:0]   func,
	input  logic [cidw_pkg::UPPER_W-1:0]  card_id_upper,
	input  logic [cidw_pkg::LOWER_W-1:0]  card_id_lower,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cidw_pkg::STATUS_W-1:0] status,
	output logic [cidw_pkg::SLOT_IDX_W-1:0] slot_index
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	// Sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]               state_q;
	cidw_pkg::func_t          func_q;
	cidw_pkg::card_id_t       id_q;
	logic [IDX_W-1:0]         rd_addr_q;
	logic                     cmp_vld_s1;
	logic [IDX_W-1:0]         cmp_idx_s1;
	cidw_pkg::card_id_t       rd_data_s1;
	logic                     hit_found_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic                     free_found_q;
	logic [IDX_W-1:0]         free_idx_q;
	logic [SLOT_COUNT-1:0]    slot_used_q;
	cidw_pkg::card_id_t       id_mem [SLOT_COUNT];

	logic                     out_valid_q;
	cidw_pkg::status_t        status_q;
	cidw_pkg::slot_idx_t      slot_index_q;

	logic                     in_fire;
	logic                     fin_fire;
	logic                     cmp_used;
	logic                     cmp_match;
	cidw_pkg::status_t        status_d;
	logic [IDX_W-1:0]         slot_d;
	logic                     mem_we;
	logic                     clr_used;

	assign in_stall   = (state_q != S_IDLE);
	assign in_fire    = in_valid && !in_stall;
	assign fin_fire   = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_index = slot_index_q;

	// Compare stage: read data of the previous cycle against the request id
	assign cmp_used  = slot_used_q[cmp_idx_s1];
	assign cmp_match = cmp_used && (rd_data_s1 == id_q);

	// Result decode from the scan outcome
	always_comb begin
		status_d = cidw_pkg::STAT_DENIED;
		slot_d   = '0;
		mem_we   = 1'b0;
		clr_used = 1'b0;
		unique case (func_q)
			cidw_pkg::FUNC_CHECK: begin
				if (hit_found_q) begin
					status_d = cidw_pkg::STAT_GRANTED;
					slot_d   = hit_idx_q;
				end
			end
			cidw_pkg::FUNC_ADD: begin
				if (!free_found_q) begin
					status_d = cidw_pkg::STAT_FULL;
				end else if (hit_found_q) begin
					status_d = cidw_pkg::STAT_PRESENT;
					slot_d   = hit_idx_q;
				end else begin
					status_d = cidw_pkg::STAT_ADDED;
					slot_d   = free_idx_q;
					mem_we   = fin_fire;
				end
			end
			cidw_pkg::FUNC_REMOVE: begin
				if (hit_found_q) begin
					status_d = cidw_pkg::STAT_REMOVED;
					slot_d   = hit_idx_q;
					clr_used = fin_fire;
				end else begin
					status_d = cidw_pkg::STAT_NOTFOUND;
				end
			end
			default: begin
				status_d = cidw_pkg::STAT_DENIED;
			end
		endcase
	end

	// Identifier memory: one write port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			id_mem[free_idx_q] <= id_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= id_mem[rd_addr_q];
	end

	// Request payload and compare-stage index
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= func;
			id_q   <= {card_id_upper, card_id_lower};
		end
		cmp_idx_s1 <= rd_addr_q;
	end

	// Sequencer, scan flags and used marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_addr_q    <= '0;
			cmp_vld_s1   <= 1'b0;
			hit_found_q  <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			slot_used_q  <= '0;
		end else begin
			cmp_vld_s1 <= (state_q == S_SCAN);

			if (cmp_vld_s1) begin
				if (cmp_match && !hit_found_q) begin
					hit_found_q <= 1'b1;
					hit_idx_q   <= cmp_idx_s1;
				end
				if (!cmp_used && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= cmp_idx_s1;
				end
			end

			if (mem_we) begin
				slot_used_q[free_idx_q] <= 1'b1;
			end
			if (clr_used) begin
				slot_used_q[hit_idx_q] <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						rd_addr_q    <= '0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						// unused operation skips the scan
						if (func == cidw_pkg::FUNC_CHECK || func == cidw_pkg::FUNC_ADD ||
								func == cidw_pkg::FUNC_REMOVE) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (rd_addr_q == LAST_IDX) begin
						state_q <= S_WAIT;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				S_WAIT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			status_q     <= status_d;
			slot_index_q <= cidw_pkg::SLOT_IDX_W'(slot_d);
		end
	end

	// Checks
	`CIDW_ASSERT_NEXT(a_add_marks_used, mem_we, slot_used_q[$past(free_idx_q)],
		"added slot not marked used")
	`CIDW_ASSERT_NOW(a_add_into_free, mem_we, !slot_used_q[free_idx_q],
		"add writes into a used slot")
	`CIDW_ASSERT_NOW(a_remove_used, clr_used, slot_used_q[hit_idx_q],
		"remove frees a slot that is not used")
	`CIDW_ASSERT_NEXT(a_cmp_after_read, state_q == S_SCAN, cmp_vld_s1,
		"scan read without a compare")
	`CIDW_ASSERT_NOW(a_no_result_overwrite, fin_fire, !out_valid_q || !out_stall,
		"result overwritten while held")

endmodule
